>>> src/sfhp_pkg.sv
package sfhp_pkg;

   // Ethertypes recognized at the link header.
   localparam logic [15:0] ETYPE_VLAN = 16'h8100;
   localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   // Byte positions where ethertypes end, and network header starts.
   localparam logic [6:0] POS_OUTER_TYPE = 7'd13;
   localparam logic [6:0] POS_INNER_TYPE = 7'd17;
   localparam logic [6:0] POS_THIRD_TYPE = 7'd21;
   localparam logic [6:0] POS_MAX        = 7'd127;
   localparam logic [4:0] OFF_RAW        = 5'd0;
   localparam logic [4:0] OFF_UNTAGGED   = 5'd14;
   localparam logic [4:0] OFF_ONE_TAG    = 5'd18;
   localparam logic [4:0] OFF_TWO_TAGS   = 5'd22;

   // Offsets of address words inside the network header.
   localparam logic [6:0] REL_V4_SRC_END = 7'd15;
   localparam logic [6:0] REL_V4_DST_END = 7'd19;
   localparam logic [6:0] REL_V6_SRC_LO  = 7'd8;
   localparam logic [6:0] REL_V6_SRC_HI  = 7'd23;
   localparam logic [6:0] REL_V6_DST_LO  = 7'd24;
   localparam logic [6:0] REL_V6_DST_HI  = 7'd39;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_V4    = 2'd1,
      KIND_V6    = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   // One classified byte, handed from the front to the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      kind_type   fr_kind;
      logic       fr_active;
      logic [6:0] fr_rel;
      kind_type   raw_kind;
      logic       raw_sel;
      logic [6:0] pos;
   } entry_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
   } acc_pair_type;

   function automatic kind_type kind_of(logic [15:0] ethertype);
      kind_type k;
      if (ethertype == ETYPE_IPV4) begin
         k = KIND_V4;
      end else if (ethertype == ETYPE_IPV6) begin
         k = KIND_V6;
      end else begin
         k = KIND_OTHER;
      end
      return k;
   endfunction

   function automatic logic is_tag(logic [15:0] ethertype);
      return (ethertype == ETYPE_VLAN) || (ethertype == ETYPE_QINQ);
   endfunction

   // Folds the word that ends at this byte into the address accumulators.
   function automatic acc_pair_type gather(kind_type kind, logic [6:0] rel,
                                           acc_pair_type acc, logic [31:0] w);
      acc_pair_type r;
      r = acc;
      if (kind == KIND_V4) begin
         if (rel == REL_V4_SRC_END) begin
            r.src = w;
         end else if (rel == REL_V4_DST_END) begin
            r.dst = w;
         end
      end else if (kind == KIND_V6 && rel[1:0] == 2'b11) begin
         if (rel >= REL_V6_SRC_LO && rel <= REL_V6_SRC_HI) begin
            r.src = acc.src ^ w;
         end else if (rel >= REL_V6_DST_LO && rel <= REL_V6_DST_HI) begin
            r.dst = acc.dst ^ w;
         end
      end
      return r;
   endfunction

   // Final hash of one view; incomplete addresses are dropped.
   function automatic logic [31:0] finish(kind_type kind, logic [6:0] rel_last,
                                          acc_pair_type acc);
      logic [31:0] s;
      logic [31:0] d;
      logic [31:0] h;
      s = '0;
      d = '0;
      h = '0;
      if (kind == KIND_V4) begin
         if (rel_last >= REL_V4_DST_END) begin
            h = acc.src + acc.dst;
         end
      end else if (kind == KIND_V6) begin
         if (rel_last >= REL_V6_SRC_HI) begin
            s = acc.src;
         end
         if (rel_last >= REL_V6_DST_HI) begin
            d = acc.dst;
         end
         h = s + d;
      end
      return h;
   endfunction

endpackage

>>> src/sfhp_req_if.sv
interface sfhp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [15:0] link_protocol;

   modport source (output valid, data_byte, first_byte, last_byte, link_protocol,
                   input ready);
   modport sink (input valid, data_byte, first_byte, last_byte, link_protocol,
                 output ready);
endinterface

>>> src/sfhp_rsp_if.sv
interface sfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] flow_hash;

   modport source (output valid, flow_hash, input ready);
   modport sink (input valid, flow_hash, output ready);
endinterface

>>> src/sfhp_front.sv
module sfhp_front
   import sfhp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   sfhp_req_if.sink        req_chan,
   input  logic            queue_full,
   output logic            push_valid,
   output entry_type       push_entry
);

   logic [6:0]  pos_ff, pos_in;
   logic [15:0] type_ff, type_in;
   kind_type    kind_ff, kind_in;
   logic [4:0]  off_ff, off_in;
   logic [15:0] proto_ff, proto_in;

   logic [6:0]  p;
   logic [15:0] tw;
   kind_type    k;
   logic [4:0]  off;
   kind_type    nk;
   logic [4:0]  noff;
   logic [6:0]  off_ext;

   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;

   // Classify the current byte against the frame state.
   always_comb begin
      p        = req_chan.first_byte ? 7'd0 : pos_ff;
      tw       = {(req_chan.first_byte ? 8'd0 : type_ff[7:0]), req_chan.data_byte};
      k        = req_chan.first_byte ? KIND_NONE : kind_ff;
      off      = req_chan.first_byte ? OFF_RAW : off_ff;
      proto_in = req_chan.first_byte ? req_chan.link_protocol : proto_ff;
      nk       = k;
      noff     = off;

      // Ethertype decisions at the end of each candidate type field.
      if (k == KIND_NONE) begin
         if (p == POS_OUTER_TYPE && off == OFF_RAW) begin
            if (is_tag(tw)) begin
               noff = OFF_ONE_TAG;
            end else begin
               nk   = kind_of(tw);
               noff = (nk == KIND_OTHER) ? OFF_RAW : OFF_UNTAGGED;
            end
         end else if (p == POS_INNER_TYPE && off == OFF_ONE_TAG) begin
            if (is_tag(tw)) begin
               noff = OFF_TWO_TAGS;
            end else begin
               nk = kind_of(tw);
            end
         end else if (p == POS_THIRD_TYPE && off == OFF_TWO_TAGS) begin
            nk = kind_of(tw);
         end
      end

      off_ext               = {2'b00, noff};
      push_entry.data_byte  = req_chan.data_byte;
      push_entry.first_byte = req_chan.first_byte;
      push_entry.last_byte  = req_chan.last_byte;
      push_entry.fr_kind    = nk;
      push_entry.fr_active  = (nk == KIND_V4 || nk == KIND_V6) && (p >= off_ext);
      push_entry.fr_rel     = p - off_ext;
      push_entry.raw_kind   = kind_of(proto_in);
      push_entry.raw_sel    = (nk == KIND_OTHER) && (noff == OFF_RAW);
      push_entry.pos        = p;

      // Frame state after this byte.
      if (req_chan.last_byte) begin
         pos_in  = '0;
         type_in = '0;
         kind_in = KIND_NONE;
         off_in  = OFF_RAW;
      end else begin
         pos_in  = (p == POS_MAX) ? p : p + 7'd1;
         type_in = tw;
         kind_in = nk;
         off_in  = noff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= '0;
         kind_ff  <= KIND_NONE;
         off_ff   <= OFF_RAW;
         proto_ff <= '0;
      end else if (push_valid) begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         kind_ff  <= kind_in;
         off_ff   <= off_in;
         proto_ff <= proto_in;
      end
   end

endmodule

>>> src/sfhp_queue.sv
module sfhp_queue
   import sfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  entry_type  push_entry,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output entry_type  head_entry
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_pop;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_in    = push_valid ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

>>> src/sfhp_back.sv
module sfhp_back
   import sfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   sfhp_rsp_if.source rsp_chan
);

   logic [31:0]  word_ff, word_in;
   acc_pair_type frm_ff, frm_in;
   acc_pair_type raw_ff, raw_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  hash_ff, hash_in;

   logic         out_free;
   logic [31:0]  base_word;
   acc_pair_type base_frm;
   acc_pair_type base_raw;
   logic [31:0]  w;
   acc_pair_type frm_new;
   acc_pair_type raw_new;
   logic [31:0]  hash;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.flow_hash = hash_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      pop      = head_valid && (!head_entry.last_byte || out_free);

      // A first byte starts from a cleared frame.
      base_word = head_entry.first_byte ? 32'd0 : word_ff;
      base_frm  = head_entry.first_byte ? '0 : frm_ff;
      base_raw  = head_entry.first_byte ? '0 : raw_ff;
      w         = {base_word[23:0], head_entry.data_byte};

      // Framed view and raw layer-3 view accumulate side by side.
      frm_new = head_entry.fr_active
              ? gather(head_entry.fr_kind, head_entry.fr_rel, base_frm, w) : base_frm;
      raw_new = gather(head_entry.raw_kind, head_entry.pos, base_raw, w);

      if (head_entry.fr_active) begin
         hash = finish(head_entry.fr_kind, head_entry.fr_rel, frm_new);
      end else if (head_entry.raw_sel) begin
         hash = finish(head_entry.raw_kind, head_entry.pos, raw_new);
      end else begin
         hash = '0;
      end

      word_in = word_ff;
      frm_in  = frm_ff;
      raw_in  = raw_ff;
      if (pop) begin
         if (head_entry.last_byte) begin
            word_in = '0;
            frm_in  = '0;
            raw_in  = '0;
         end else begin
            word_in = w;
            frm_in  = frm_new;
            raw_in  = raw_new;
         end
      end

      // Output register takes a new hash once the old one is gone.
      rsp_valid_in = rsp_valid_ff;
      hash_in      = hash_ff;
      if (out_free) begin
         rsp_valid_in = pop && head_entry.last_byte;
         hash_in      = hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         frm_ff       <= '0;
         raw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         frm_ff       <= frm_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

endmodule

>>> src/symmetric_flow_hash_parser.sv
// Symmetric flow hash parser.
//
// The req_chan channel carries one frame byte per request, with first and
// last markers and the link protocol that is sampled with the first byte.
// The rsp_chan channel carries one 32-bit flow hash per frame, issued for
// the request that holds the last byte; no other request gives a response.
//
// A request is taken in every cycle while the four-entry queue between the
// classifier and the hash unit has room, so the sustained rate is one byte
// per clock. The hash for a frame is loaded into the response register
// when its last byte leaves the queue, after any bytes queued ahead of it,
// and is offered on rsp_chan from that register.
//
// Reset is synchronous and active high. It empties the queue, drops any
// pending response and returns the frame state, including the sampled
// link protocol, to zero. When the receiver stalls, the response register
// holds its hash; bytes keep flowing until a last byte reaches the hash
// unit, then the queue fills and req_chan.ready falls.
module symmetric_flow_hash_parser
   import sfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sfhp_req_if.sink   req_chan,
   sfhp_rsp_if.source rsp_chan
);

   logic      push_valid;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   sfhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   sfhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sfhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> src/sfhp_checker.sv
module sfhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash
);

   logic [3:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready && req_last;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Frames whose last byte went in and whose hash has not come out.
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 4'd1;
      end else if (!req_fire && rsp_fire && pending_ff != 4'd0) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response is offered only for a frame that has ended.
   a_no_unasked_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without a pending last byte");

   // Reset drops any response in flight.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays offered.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled hash does not change.
   a_hash_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash))
      else $error("hash changed while stalled");

endmodule

bind symmetric_flow_hash_parser sfhp_checker u_sfhp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_byte),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.flow_hash)
);
